// ----- src/cam_pkg.sv -----
// ----------------------------------------------------------------------------
// cam_pkg
// Shared types and constants for the column argmax/argmin streamer.
// ----------------------------------------------------------------------------
`default_nettype none

package cam_pkg;

  // fixed field widths of the stream and configuration ports
  localparam int SAMPLE_W   = 8;
  localparam int COLUMN_W   = 8;
  localparam int BEST_ROW_W = 16;
  localparam int CFG_COLS_W = 9;
  localparam int CFG_ROWS_W = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COL_COUNT = 2'd0,
    CFG_NUM_ROWS  = 2'd1,
    CFG_FIND_MAX  = 2'd2
  } cfg_index_t;

  // position flags of one matrix byte
  typedef struct packed {
    logic last_col;
    logic last_row;
  } cam_flags_t;

endpackage : cam_pkg

`default_nettype wire

// ----- src/cam_ctrl.sv -----
// ----------------------------------------------------------------------------
// cam_ctrl
// Row/column position counters and sample conditioning for each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cam_ctrl #(
  parameter int MAX_COLS       = 256,
  parameter int ROW_INDEX_BITS = 16,
  parameter int COL_W          = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic [cam_pkg::SAMPLE_W-1:0]   sample,
  input  wire logic [cam_pkg::CFG_COLS_W-1:0] col_limit,
  input  wire logic [cam_pkg::CFG_ROWS_W-1:0] num_rows,
  input  wire logic                           find_max,
  output logic      [COL_W-1:0]               item_col,
  output logic      [ROW_INDEX_BITS-1:0]      item_row,
  output logic      [cam_pkg::SAMPLE_W-1:0]   item_value,
  output cam_pkg::cam_flags_t                 item_flags
);

  import cam_pkg::*;

  localparam int NC_W = (COL_W + 1 > CFG_COLS_W) ? COL_W + 1 : CFG_COLS_W;
  localparam int NR_W = (ROW_INDEX_BITS + 1 > CFG_ROWS_W) ? ROW_INDEX_BITS + 1 : CFG_ROWS_W;

  logic [COL_W-1:0]          col_count_r, col_count_nxt;
  logic [ROW_INDEX_BITS-1:0] row_count_r, row_count_nxt;
  logic [COL_W-1:0]          cols_m1;
  logic [ROW_INDEX_BITS-1:0] rows_m1;

  // last column and last row indexes after clamping the register values
  always_comb begin
    if (col_limit == '0) begin
      cols_m1 = '0;
    end else if (NC_W'(col_limit) > NC_W'(MAX_COLS)) begin
      cols_m1 = COL_W'(MAX_COLS - 1);
    end else begin
      cols_m1 = COL_W'(col_limit - CFG_COLS_W'(1));
    end
  end

  always_comb begin
    if (num_rows == '0) begin
      rows_m1 = '0;
    end else if (NR_W'(num_rows) > (NR_W'(1) << ROW_INDEX_BITS)) begin
      rows_m1 = '1;
    end else begin
      rows_m1 = ROW_INDEX_BITS'(num_rows - CFG_ROWS_W'(1));
    end
  end

  assign item_col            = col_count_r;
  assign item_row            = row_count_r;
  assign item_value          = find_max ? sample : ~sample;
  assign item_flags.last_col = (col_count_r >= cols_m1);
  assign item_flags.last_row = (row_count_r >= rows_m1);

  always_comb begin
    col_count_nxt = col_count_r;
    row_count_nxt = row_count_r;
    if (accept) begin
      if (item_flags.last_col) begin
        col_count_nxt = '0;
        row_count_nxt = item_flags.last_row ? '0 : row_count_r + ROW_INDEX_BITS'(1);
      end else begin
        col_count_nxt = col_count_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= '0;
      row_count_r <= '0;
    end else begin
      col_count_r <= col_count_nxt;
      row_count_r <= row_count_nxt;
    end
  end

endmodule : cam_ctrl

`default_nettype wire

// ----- src/cam_colstore.sv -----
// ----------------------------------------------------------------------------
// cam_colstore
// Per-column best value/row memory with read-modify-write stage and bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module cam_colstore #(
  parameter int MAX_COLS       = 256,
  parameter int ROW_INDEX_BITS = 16,
  parameter int COL_W          = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [COL_W-1:0]             item_col,
  input  wire logic [ROW_INDEX_BITS-1:0]    item_row,
  input  wire logic [cam_pkg::SAMPLE_W-1:0] item_value,
  input  wire cam_pkg::cam_flags_t          item_flags,
  input  wire logic                         advance,
  output logic                              s1_valid,
  output logic      [COL_W-1:0]             res_col,
  output logic      [ROW_INDEX_BITS-1:0]    res_row,
  output cam_pkg::cam_flags_t               res_flags
);

  import cam_pkg::*;

  localparam int ENT_W = SAMPLE_W + ROW_INDEX_BITS;

  logic [ENT_W-1:0] mem [MAX_COLS];

  logic                      s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0]          s1_col_r;
  logic [ROW_INDEX_BITS-1:0] s1_row_r;
  logic [SAMPLE_W-1:0]       s1_value_r;
  cam_flags_t                s1_flags_r;
  logic [ENT_W-1:0]          rd_ent_r;
  logic                      byp_r;
  logic [ENT_W-1:0]          byp_ent_r;

  logic                      s1_fire;
  logic [ENT_W-1:0]          cur_ent;
  logic                      take;
  logic [ENT_W-1:0]          new_ent;

  assign s1_fire = s1_valid_r && advance;

  // entry written by the item leaving this cycle is forwarded to a new read
  assign cur_ent = byp_r ? byp_ent_r : rd_ent_r;
  assign take    = (s1_row_r == '0) || (s1_value_r > cur_ent[ENT_W-1 -: SAMPLE_W]);
  assign new_ent = take ? {s1_value_r, s1_row_r} : cur_ent;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r   <= item_col;
      s1_row_r   <= item_row;
      s1_value_r <= item_value;
      s1_flags_r <= item_flags;
      byp_r      <= s1_fire && (s1_col_r == item_col);
      byp_ent_r  <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mem[s1_col_r] <= new_ent;
    end
    if (accept) begin
      rd_ent_r <= mem[item_col];
    end
  end

  assign s1_valid  = s1_valid_r;
  assign res_col   = s1_col_r;
  assign res_row   = new_ent[ROW_INDEX_BITS-1:0];
  assign res_flags = s1_flags_r;

endmodule : cam_colstore

`default_nettype wire

// ----- src/column_argmax_streamer_unit.sv -----
// Column argmax/argmin streamer.
// Throughput: one byte per cycle while the output is not stalled, set by
// the one-read one-write column entry memory, with forwarding for
// back-to-back hits on the same column.
// Reset (rst_n low, synchronous): counters clear, registers return to one
// column, one row and argmax mode; the column memory is not cleared.
// ----------------------------------------------------------------------------
// column_argmax_streamer_unit
// Streams a row-major byte matrix and reports each column's best row.
// ----------------------------------------------------------------------------
`default_nettype none

module column_argmax_streamer_unit #(
  parameter int MAX_COLS       = 256,
  parameter int ROW_INDEX_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // slave side: tdata = sample[7:0]
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [cam_pkg::SAMPLE_W-1:0]   in_tdata,
  // master side: tdata = column[7:0], best_row[23:8]; tlast = last_col
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [cam_pkg::COLUMN_W+cam_pkg::BEST_ROW_W-1:0] out_tdata,
  output logic                                out_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [cam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cam_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import cam_pkg::*;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [CFG_COLS_W-1:0] col_limit_r;
  logic [CFG_ROWS_W-1:0] num_rows_r;
  logic                  find_max_r;

  logic                      accept;
  logic                      advance;
  logic                      s1_valid;
  logic                      s1_fire;
  logic [COL_W-1:0]          item_col;
  logic [ROW_INDEX_BITS-1:0] item_row;
  logic [SAMPLE_W-1:0]       item_value;
  cam_flags_t                item_flags;
  logic [COL_W-1:0]          res_col;
  logic [ROW_INDEX_BITS-1:0] res_row;
  cam_flags_t                res_flags;

  logic                  out_valid_r, out_valid_nxt;
  logic [COLUMN_W-1:0]   column_r;
  logic [BEST_ROW_W-1:0] best_row_r;
  logic                  last_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_limit_r <= CFG_COLS_W'(1);
      num_rows_r  <= CFG_ROWS_W'(1);
      find_max_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COL_COUNT: col_limit_r <= cfg_wdata[CFG_COLS_W-1:0];
        CFG_NUM_ROWS:  num_rows_r  <= cfg_wdata[CFG_ROWS_W-1:0];
        CFG_FIND_MAX:  find_max_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid || advance;
  assign accept    = in_tvalid && in_tready;
  assign s1_fire   = s1_valid && advance;

  cam_ctrl #(
    .MAX_COLS       (MAX_COLS),
    .ROW_INDEX_BITS (ROW_INDEX_BITS),
    .COL_W          (COL_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_tdata),
    .col_limit  (col_limit_r),
    .num_rows   (num_rows_r),
    .find_max   (find_max_r),
    .item_col   (item_col),
    .item_row   (item_row),
    .item_value (item_value),
    .item_flags (item_flags)
  );

  cam_colstore #(
    .MAX_COLS       (MAX_COLS),
    .ROW_INDEX_BITS (ROW_INDEX_BITS),
    .COL_W          (COL_W)
  ) u_colstore (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item_col   (item_col),
    .item_row   (item_row),
    .item_value (item_value),
    .item_flags (item_flags),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .res_col    (res_col),
    .res_row    (res_row),
    .res_flags  (res_flags)
  );

  // only bytes of the last row produce a result transaction
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = res_flags.last_row;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      column_r   <= COLUMN_W'(res_col);
      best_row_r <= BEST_ROW_W'(res_row);
      last_col_r <= res_flags.last_col;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {best_row_r, column_r};
  assign out_tlast  = last_col_r;

endmodule : column_argmax_streamer_unit

`default_nettype wire

// ----- src/cam_checker.sv -----
// ----------------------------------------------------------------------------
// cam_checker
// Port-level checks of the column argmax/argmin streamer.
// ----------------------------------------------------------------------------
`default_nettype none

module cam_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [cam_pkg::COLUMN_W+cam_pkg::BEST_ROW_W-1:0] out_tdata,
  input wire logic                           out_tlast
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result transaction changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // with the output register empty the pipeline always takes a new byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register empty");

  // a fresh result comes from a byte accepted earlier
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input transaction");

endmodule : cam_checker

bind column_argmax_streamer_unit cam_checker u_cam_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ----- tb/column_argmax_streamer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_argmax_streamer_unit_tb
// Self-checking bench for the column argmax/argmin streamer. Streams byte
// matrices through the block under several shapes, modes and idle/stall
// patterns. A local model tracks each column's best value and row, and
// checks every result transaction against it in order.
// ----------------------------------------------------------------------------

module column_argmax_streamer_unit_tb;
  import cam_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 4;

  typedef struct packed {
    logic [COLUMN_W-1:0]   column;
    logic [BEST_ROW_W-1:0] best_row;
    logic                  last_col;
  } col_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [COLUMN_W+BEST_ROW_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COL_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  column_argmax_streamer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // stimulus and expectation stores
  logic [SAMPLE_W-1:0] sample_q[$];
  col_result_t         col_results_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int samples_queued = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;

  // column tracker state
  logic [CFG_COLS_W-1:0] reg_cols = 9'd1;
  logic [CFG_ROWS_W-1:0] reg_rows = 17'd1;
  logic                  reg_find_max = 1'b1;
  logic [7:0]            trk_col = '0;
  logic [15:0]           trk_row = '0;
  logic [7:0]            col_best_val[256];
  logic [15:0]           col_best_row[256];

  function automatic int unsigned eff_cols();
    int unsigned c;
    c = 32'(reg_cols);
    if (c == 0) c = 1;
    if (c > 256) c = 256;
    return c;
  endfunction

  function automatic int unsigned eff_rows();
    int unsigned r;
    r = 32'(reg_rows);
    if (r == 0) r = 1;
    if (r > 65536) r = 65536;
    return r;
  endfunction

  // update the column entry for one accepted byte, queue its result if any
  function automatic void track_sample(input logic [SAMPLE_W-1:0] sample);
    logic [7:0] v;
    int unsigned nc, nr;
    bit lc, lr;
    col_result_t r;
    nc = eff_cols();
    nr = eff_rows();
    v = reg_find_max ? sample : ~sample;
    if (trk_row == 0 || v > col_best_val[trk_col]) begin
      col_best_val[trk_col] = v;
      col_best_row[trk_col] = trk_row;
    end
    lc = trk_col >= nc - 1;
    lr = trk_row >= nr - 1;
    if (lr) begin
      r.column   = trk_col;
      r.best_row = col_best_row[trk_col];
      r.last_col = lc;
      col_results_q.push_back(r);
    end
    if (lc) begin
      trk_col = '0;
      trk_row = lr ? 16'd0 : trk_row + 16'd1;
    end else begin
      trk_col = trk_col + 8'd1;
    end
  endfunction

  function automatic int unsigned samples_to_matrix_end();
    int unsigned nc, nr, left;
    nc = eff_cols();
    nr = eff_rows();
    left = (trk_col >= nc - 1) ? 1 : nc - trk_col;
    if (trk_row < nr - 1) left += (nr - 1 - trk_row) * nc;
    return left;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(3))
      0: return 8'($urandom_range(0, 3));
      1: return 8'(255 - $urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) track_sample(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= sample_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    col_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.column   = out_tdata[COLUMN_W-1:0];
        got.best_row = out_tdata[COLUMN_W +: BEST_ROW_W];
        got.last_col = out_tlast;
        if (col_results_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: column=%0d best_row=%0d last_col=%0b",
                     got.column, got.best_row, got.last_col);
        end else begin
          want = col_results_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"result mismatch: expected column=%0d best_row=%0d ",
                        "last_col=%0b, got column=%0d best_row=%0d last_col=%0b"},
                       want.column, want.best_row, want.last_col,
                       got.column, got.best_row, got.last_col);
          end
        end
      end
      out_tready <= (hold_left == 0 && !hold_req) &&
                    ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // block drained: nothing queued, nothing offered, no result outstanding
  task automatic wait_idle();
    while (sample_q.size() != 0 || in_tvalid || col_results_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_COL_COUNT: reg_cols = val[CFG_COLS_W-1:0];
      CFG_NUM_ROWS:  reg_rows = val[CFG_ROWS_W-1:0];
      CFG_FIND_MAX:  reg_find_max = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) sample_q.push_back(rand_sample());
    samples_queued += n;
  endtask

  task automatic random_matrix();
    int unsigned c, r, total, part;
    c = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
    r = $urandom_range(0, 6);
    wait_idle();
    write_reg(CFG_COL_COUNT, CFG_DATA_W'(c));
    write_reg(CFG_NUM_ROWS, CFG_DATA_W'(r));
    write_reg(CFG_FIND_MAX, CFG_DATA_W'($urandom_range(1)));
    total = samples_to_matrix_end();
    if (total > 1 && $urandom_range(4) == 0) begin
      // reshape partway through the matrix
      part = $urandom_range(1, total - 1);
      queue_random(part);
      wait_idle();
      write_reg(CFG_COL_COUNT, CFG_DATA_W'($urandom_range(0, 12)));
      write_reg(CFG_NUM_ROWS, CFG_DATA_W'($urandom_range(0, 8)));
      write_reg(CFG_FIND_MAX, CFG_DATA_W'($urandom_range(1)));
      queue_random(samples_to_matrix_end());
    end else begin
      queue_random(total);
    end
  endtask

  initial begin
    int phase_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset shape: 1x1 argmax
    sample_q = {sample_q, 8'd0, 8'd255};

    // 3x3 argmax with ties kept at the smallest row
    wait_idle();
    write_reg(CFG_COL_COUNT, 3);
    write_reg(CFG_NUM_ROWS, 3);
    write_reg(CFG_FIND_MAX, 1);
    sample_q = {sample_q, 8'd10, 8'd255, 8'd0, 8'd10, 8'd0, 8'd1, 8'd11, 8'd255, 8'd0};

    // 2x2 argmin
    wait_idle();
    write_reg(CFG_COL_COUNT, 2);
    write_reg(CFG_NUM_ROWS, 2);
    write_reg(CFG_FIND_MAX, 0);
    sample_q = {sample_q, 8'd0, 8'd255, 8'd0, 8'd254};

    // zero shape registers act as one
    wait_idle();
    write_reg(CFG_COL_COUNT, 0);
    write_reg(CFG_NUM_ROWS, 0);
    sample_q = {sample_q, 8'd128, 8'd7};

    // oversized shape, then shrunk below the counters mid-row
    wait_idle();
    write_reg(CFG_COL_COUNT, 17'h001FF);
    write_reg(CFG_NUM_ROWS, 17'h1FFFF);
    write_reg(CFG_FIND_MAX, 1);
    sample_q = {sample_q, 8'd200, 8'd100, 8'd50};
    wait_idle();
    write_reg(CFG_NUM_ROWS, 1);
    write_reg(CFG_COL_COUNT, 3);
    repeat (samples_to_matrix_end()) sample_q.push_back(8'd1);

    // rows cut below the row counter, mode flipped mid-matrix
    wait_idle();
    write_reg(CFG_COL_COUNT, 2);
    write_reg(CFG_NUM_ROWS, 4);
    sample_q = {sample_q, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9};
    wait_idle();
    write_reg(CFG_NUM_ROWS, 2);
    write_reg(CFG_FIND_MAX, 0);
    repeat (samples_to_matrix_end()) sample_q.push_back(8'd0);

    // full-width single-row matrix writes every column entry
    wait_idle();
    write_reg(CFG_COL_COUNT, 256);
    write_reg(CFG_NUM_ROWS, 1);
    write_reg(CFG_FIND_MAX, 1);
    queue_random(256);

    // receiver holds off while the sender keeps offering
    wait_idle();
    write_reg(CFG_COL_COUNT, 16);
    write_reg(CFG_NUM_ROWS, 4);
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    queue_random(64);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      phase_start = samples_queued;
      while (samples_queued - phase_start < 180) random_matrix();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && col_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
